[rtl/core/tef_pkg.sv]
// ----------------------------------------------------------------------------
// tef_pkg
// Shared types and constants of the timestamped event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tef_pkg;

  localparam int CAPACITY = 256;
  localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);

  localparam int DATA_W  = 8;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 8;

  localparam logic [CFG_W-1:0] LATENCY_LIMIT_RST = 32'd1000000;
  localparam logic [CFG_W-1:0] BUSY_LIMIT_RST    = 32'd500000;
  localparam logic [CFG_W-1:0] IDLE_LIMIT_RST    = 32'd1000000;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_TAKE   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_STATUS = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    WAIT_NONE  = 2'd0,
    WAIT_SHORT = 2'd1,
    WAIT_LONG  = 2'd2
  } wait_t;

  typedef enum logic [1:0] {
    CFG_LATENCY = 2'd0,
    CFG_BUSY    = 2'd1,
    CFG_IDLE    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0]  value;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Bookkeeping carried from the accept stage to the evaluate stage.
  typedef struct packed {
    logic               valid;
    logic               add_ok;
    logic               take_ok;
    logic               take_empty;
    logic [STAMP_W-1:0] now;
    logic [PTR_W-1:0]   cnt;
    logic [PTR_W-1:0]   rd_ptr;
    logic [PTR_W-1:0]   wr_ptr;
    logic [31:0]        miss_run;
  } stage_t;

  // Pointer / count as reported on the 8-bit result ports.
  function automatic logic [IDX_W-1:0] to_idx(input logic [PTR_W-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    return wide[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/tef_entry_ram.sv]
// ----------------------------------------------------------------------------
// tef_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tef_entry_ram (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [tef_pkg::PTR_W-1:0] wr_addr,
  input  wire tef_pkg::entry_t           wr_entry,
  input  wire logic                      rd_en,
  input  wire logic [tef_pkg::PTR_W-1:0] rd_addr,
  output tef_pkg::entry_t                rd_entry
);

  tef_pkg::entry_t mem [tef_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/timestamped_event_fifo.sv]
// ----------------------------------------------------------------------------
// timestamped_event_fifo
// Ring-buffer queue of byte events stamped with their arrival time.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an operation (add, take, clear, status) with an event
//   byte and the current time transfers at a rising edge with start high and
//   busy low. busy is always low: a command can transfer every cycle.
//   Result channel: out_valid rises at the edge after the transfer edge and
//   marks one result for exactly one cycle. Results come back in command
//   order. The receiver cannot stall; results must be taken as they appear.
//   Throughput: 1 command per cycle. Results pass through the registered
//   read of the entry store followed by the result register.
//   Queue state (count, pointers, empty-take counter) is updated at the
//   transfer edge itself, so back-to-back commands see each other's effects.
//   Config: cfg_we writes latency/busy/idle limits by cfg_index; index 3 is
//   ignored. Write only while no command is in flight.
//   Reset (rst_n low, synchronous): queue empty, pointers and counter zero,
//   limits back to defaults, nothing in flight. Entry store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamped_event_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_operation,
  input  wire logic [tef_pkg::DATA_W-1:0]    in_data_in,
  input  wire logic [tef_pkg::STAMP_W-1:0]   in_now,
  // result channel
  output logic                               out_valid,
  output logic                               out_ok,
  output logic [tef_pkg::DATA_W-1:0]         out_data_out,
  output logic                               out_late,
  output logic [1:0]                         out_wait_class,
  output logic [tef_pkg::IDX_W-1:0]          out_fill_count,
  output logic [tef_pkg::IDX_W-1:0]          out_read_index,
  output logic [tef_pkg::IDX_W-1:0]          out_write_index,
  output logic [31:0]                        out_empty_take_total,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [tef_pkg::CFG_W-1:0]     cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [tef_pkg::CFG_W-1:0] latency_limit_r;
  logic [tef_pkg::CFG_W-1:0] busy_limit_r;
  logic [tef_pkg::CFG_W-1:0] idle_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latency_limit_r <= tef_pkg::LATENCY_LIMIT_RST;
      busy_limit_r    <= tef_pkg::BUSY_LIMIT_RST;
      idle_limit_r    <= tef_pkg::IDLE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (tef_pkg::cfg_idx_t'(cfg_index))
        tef_pkg::CFG_LATENCY: latency_limit_r <= cfg_data;
        tef_pkg::CFG_BUSY:    busy_limit_r    <= cfg_data;
        tef_pkg::CFG_IDLE:    idle_limit_r    <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Accept stage: queue bookkeeping updated at the transfer edge
  // --------------------------------------------------------------------------
  logic                      accept;
  logic [tef_pkg::PTR_W-1:0] cnt_r,  cnt_nxt;
  logic [tef_pkg::PTR_W-1:0] rd_r,   rd_nxt;
  logic [tef_pkg::PTR_W-1:0] wr_r,   wr_nxt;
  logic [31:0]               et_r,   et_nxt;
  logic                      add_ok, take_ok, take_empty;
  tef_pkg::stage_t           s1_r,   s1_nxt;
  tef_pkg::entry_t           wr_entry, rd_entry;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    cnt_nxt    = cnt_r;
    rd_nxt     = rd_r;
    wr_nxt     = wr_r;
    et_nxt     = et_r;
    add_ok     = 1'b0;
    take_ok    = 1'b0;
    take_empty = 1'b0;
    unique case (tef_pkg::op_t'(in_operation))
      tef_pkg::OP_ADD: begin
        // one slot stays free: refuse when count would reach capacity
        if (cnt_r != tef_pkg::PTR_LAST) begin
          add_ok  = 1'b1;
          cnt_nxt = cnt_r + tef_pkg::PTR_ONE;
          wr_nxt  = (wr_r == tef_pkg::PTR_LAST) ? '0 : wr_r + tef_pkg::PTR_ONE;
        end
      end
      tef_pkg::OP_TAKE: begin
        if (cnt_r == '0) begin
          take_empty = 1'b1;
          if (et_r != '1) begin
            et_nxt = et_r + 32'd1;
          end
        end else begin
          take_ok = 1'b1;
          cnt_nxt = cnt_r - tef_pkg::PTR_ONE;
          rd_nxt  = (rd_r == tef_pkg::PTR_LAST) ? '0 : rd_r + tef_pkg::PTR_ONE;
          et_nxt  = '0;
        end
      end
      tef_pkg::OP_CLEAR: begin
        cnt_nxt = '0;
        rd_nxt  = '0;
        wr_nxt  = '0;
        et_nxt  = '0;
      end
      tef_pkg::OP_STATUS: ;
      default: ;
    endcase

    s1_nxt.valid      = accept;
    s1_nxt.add_ok     = add_ok;
    s1_nxt.take_ok    = take_ok;
    s1_nxt.take_empty = take_empty;
    s1_nxt.now        = in_now;
    s1_nxt.cnt        = cnt_nxt;
    s1_nxt.rd_ptr     = rd_nxt;
    s1_nxt.wr_ptr     = wr_nxt;
    s1_nxt.miss_run   = et_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
      wr_r  <= '0;
      et_r  <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      et_r  <= et_nxt;
    end
  end

  // stage register: only the valid bit is reset, payload follows freely
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= s1_nxt.valid;
    end
    s1_r.add_ok     <= s1_nxt.add_ok;
    s1_r.take_ok    <= s1_nxt.take_ok;
    s1_r.take_empty <= s1_nxt.take_empty;
    s1_r.now        <= s1_nxt.now;
    s1_r.cnt        <= s1_nxt.cnt;
    s1_r.rd_ptr     <= s1_nxt.rd_ptr;
    s1_r.wr_ptr     <= s1_nxt.wr_ptr;
    s1_r.miss_run   <= s1_nxt.miss_run;
  end

  // --------------------------------------------------------------------------
  // Entry store: write on a stored add, read the head on every transfer.
  // An add both writes and reads, but read data is used only by a take, so no bypass is needed.
  // --------------------------------------------------------------------------
  assign wr_entry.value = in_data_in;
  assign wr_entry.stamp = in_now;

  tef_entry_ram u_ram (
    .clk      (clk),
    .wr_en    (accept && add_ok),
    .wr_addr  (wr_r),
    .wr_entry (wr_entry),
    .rd_en    (accept),
    .rd_addr  (rd_r),
    .rd_entry (rd_entry)
  );

  // --------------------------------------------------------------------------
  // Evaluate stage: latency check and wait class, into the result register
  // --------------------------------------------------------------------------
  logic [tef_pkg::STAMP_W-1:0] delta;
  logic                        late_nxt;
  tef_pkg::wait_t              wclass_nxt;
  logic [tef_pkg::DATA_W-1:0]  dout_nxt;

  always_comb begin
    delta    = s1_r.now - rd_entry.stamp;  // wraps modulo 2^32
    late_nxt = s1_r.take_ok && (delta > latency_limit_r);
    dout_nxt = s1_r.take_ok ? rd_entry.value : '0;
    priority if (!s1_r.take_empty) begin
      wclass_nxt = tef_pkg::WAIT_NONE;
    end else if (s1_r.miss_run < busy_limit_r) begin
      wclass_nxt = tef_pkg::WAIT_NONE;
    end else if (s1_r.miss_run < idle_limit_r) begin
      wclass_nxt = tef_pkg::WAIT_SHORT;
    end else begin
      wclass_nxt = tef_pkg::WAIT_LONG;
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_ok               <= s1_r.add_ok || s1_r.take_ok;
    out_data_out         <= dout_nxt;
    out_late             <= late_nxt;
    out_wait_class       <= wclass_nxt;
    out_fill_count       <= tef_pkg::to_idx(s1_r.cnt);
    out_read_index       <= tef_pkg::to_idx(s1_r.rd_ptr);
    out_write_index      <= tef_pkg::to_idx(s1_r.wr_ptr);
    out_empty_take_total <= s1_r.miss_run;
  end

  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // count always equals the ring distance between the pointers
  a_cnt_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_r >= rd_r) ? (cnt_r == wr_r - rd_r)
                   : (32'(cnt_r) == 32'(wr_r) + 32'(tef_pkg::CAPACITY) - 32'(rd_r)))
    else $error("fill count out of step with pointers");

  // every transfer is followed by the stage valid bit and then the result strobe
  a_two_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && accept) |=> s1_r.valid ##1 out_valid_r)
    else $error("result strobe missing");

  // a returned entry never carries a wait advice
  a_ok_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ok) |-> (out_wait_class == tef_pkg::WAIT_NONE))
    else $error("wait class on a successful operation");

  // late flag and returned data only on a successful operation
  a_late_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_late || (out_data_out != '0))) |-> out_ok)
    else $error("take payload without ok");

  // a successful take clears the empty-take counter
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && accept && take_ok) |=> (et_r == '0))
    else $error("empty-take counter not cleared");
`endif

endmodule

`default_nettype wire
